[design/mfp_pkg.sv]
// ----------------------------------------------------------------------------
// mfp_pkg
// Shared widths, codes, preset records and stage types of the meter
// front-panel controller.
// ----------------------------------------------------------------------------
package mfp_pkg;

    // record store geometry
    localparam int RECORD_DEPTH = 128;
    localparam int REC_AW       = $clog2(RECORD_DEPTH);
    localparam int REC_CW       = $clog2(RECORD_DEPTH + 1);
    localparam int PRESET_N     = 5;
    localparam int PRESET_AW    = $clog2(PRESET_N);

    // field widths
    localparam int CMD_W  = 3;
    localparam int VAL_W  = 10;
    localparam int DATE_W = 32;
    localparam int TMR_W  = 16;
    localparam int DIG_W  = 4;
    localparam int CNT_W  = 8;
    localparam int MODE_W = 2;
    localparam int KIND_W = 2;
    localparam int REC_W  = VAL_W + DATE_W;

    // configuration port
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 16;

    localparam logic [CFG_IW-1:0] CFG_SELFTEST  = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_VIEW_TO   = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_BLINK     = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_CD_TICKS  = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_CD_START  = 3'd4;

    localparam logic [TMR_W-1:0] RST_SELFTEST  = 16'd2000;
    localparam logic [TMR_W-1:0] RST_VIEW_TO   = 16'd3000;
    localparam logic [TMR_W-1:0] RST_BLINK     = 16'd500;
    localparam logic [TMR_W-1:0] RST_CD_TICKS  = 16'd300;
    localparam logic [DIG_W-1:0] RST_CD_START  = 4'd5;

    // event codes
    localparam logic [CMD_W-1:0] CMD_TICK      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POWER     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_UP        = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DOWN      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_STRIP_IN  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_BLOOD     = 3'd5;
    localparam logic [CMD_W-1:0] CMD_STRIP_OUT = 3'd6;

    // operating modes
    localparam logic [MODE_W-1:0] MODE_IDLE    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_VIEW    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MEASURE = 2'd2;

    // main digit contents
    localparam logic [KIND_W-1:0] MAIN_BLANK  = 2'd0;
    localparam logic [KIND_W-1:0] MAIN_VALUE  = 2'd1;
    localparam logic [KIND_W-1:0] MAIN_EIGHTS = 2'd2;
    localparam logic [KIND_W-1:0] MAIN_DIGIT  = 2'd3;

    // date digit contents
    localparam logic [KIND_W-1:0] DATE_BLANK  = 2'd0;
    localparam logic [KIND_W-1:0] DATE_VALUE  = 2'd1;
    localparam logic [KIND_W-1:0] DATE_EIGHTS = 2'd2;

    localparam logic [VAL_W-1:0] MEAS_MAX = 10'd999;

    // display update collected while an event is worked on
    typedef struct packed {
        logic              main_wr;
        logic [KIND_W-1:0] main_kind;
        logic              main_rec;
        logic [VAL_W-1:0]  main_val;
        logic              sec_wr;
        logic              sec;
        logic              date_wr;
        logic [KIND_W-1:0] date_kind;
        logic              date_rec;
        logic [DATE_W-1:0] date_val;
        logic              blood_wr;
        logic              blood;
        logic              strip_wr;
        logic              strip;
        logic              bat_wr;
        logic              bat;
        logic              link_wr;
        logic              link;
    } t_upd;

    // where the shown record comes from
    typedef struct packed {
        logic                 preset;
        logic [PRESET_AW-1:0] pidx;
    } t_rec_sel;

    // status after the event
    typedef struct packed {
        logic              powered;
        logic [MODE_W-1:0] mode;
        logic [CNT_W-1:0]  count;
    } t_stat;

    // factory records, never overwritten since the store only grows
    function automatic logic [VAL_W-1:0] preset_value(input logic [PRESET_AW-1:0] idx);
        logic [VAL_W-1:0] v;
        case (idx)
            3'd0:    v = 10'd123;
            3'd1:    v = 10'd103;
            3'd2:    v = 10'd83;
            3'd3:    v = 10'd73;
            3'd4:    v = 10'd133;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [DATE_W-1:0] preset_date(input logic [PRESET_AW-1:0] idx);
        logic [DATE_W-1:0] d;
        case (idx)
            3'd0:    d = 32'd2304260425;
            3'd1:    d = 32'd2304260525;
            3'd2:    d = 32'd2304260625;
            3'd3:    d = 32'd2304260725;
            3'd4:    d = 32'd2304260825;
            default: d = '0;
        endcase
        return d;
    endfunction

endpackage

[design/mfp_in_if.sv]
// ----------------------------------------------------------------------------
// mfp_in_if
// Event channel: one word is one panel event with its side values.
// ----------------------------------------------------------------------------
interface mfp_in_if;
    logic                         valid;
    logic                         ready;
    logic [mfp_pkg::CMD_W-1:0]    cmd;
    logic [mfp_pkg::VAL_W-1:0]    meas_value;
    logic [mfp_pkg::DATE_W-1:0]   clock_value;

    modport source (output valid, cmd, meas_value, clock_value, input ready);
    modport sink   (input valid, cmd, meas_value, clock_value, output ready);
endinterface

[design/mfp_out_if.sv]
// ----------------------------------------------------------------------------
// mfp_out_if
// Display channel: one word is one display snapshot.
// ----------------------------------------------------------------------------
interface mfp_out_if;
    logic                         valid;
    logic                         ready;
    logic                         powered;
    logic [mfp_pkg::MODE_W-1:0]   mode_now;
    logic [mfp_pkg::KIND_W-1:0]   main_kind;
    logic [mfp_pkg::VAL_W-1:0]    main_value;
    logic                         second_eights;
    logic [mfp_pkg::KIND_W-1:0]   date_kind;
    logic [mfp_pkg::DATE_W-1:0]   date_value;
    logic                         blood_icon;
    logic                         strip_icon;
    logic                         battery_icon;
    logic                         link_icon;
    logic [mfp_pkg::CNT_W-1:0]    stored_count;

    modport source (output valid, powered, mode_now, main_kind, main_value, second_eights,
                    date_kind, date_value, blood_icon, strip_icon, battery_icon, link_icon,
                    stored_count, input ready);
    modport sink   (input valid, powered, mode_now, main_kind, main_value, second_eights,
                    date_kind, date_value, blood_icon, strip_icon, battery_icon, link_icon,
                    stored_count, output ready);
endinterface

[design/meter_front_panel_controller.sv]
// ----------------------------------------------------------------------------
// meter_front_panel_controller
// Front-panel controller of a handheld meter: events in, display snapshots
// out, measurements kept in a record store.
// ----------------------------------------------------------------------------
// One event word is taken per clock cycle while the output is taken, and
// every event gives exactly one display word: the accepting edge loads the
// event stage and starts the registered read of the record store, and the
// output register is loaded from the event stage once it is free. The event
// stage updates all control state at the accepting edge, so back-to-back
// events run at full rate while the output is taken; the output register and
// the stage in front of it let one more event in while a snapshot waits. The
// five factory records come from a constant table and the store only grows,
// so no clearing pass is needed after reset. Configuration may be written
// whenever no event is in flight.
module meter_front_panel_controller (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [mfp_pkg::CFG_IW-1:0]   i_cfg_idx,
    input  logic [mfp_pkg::CFG_DW-1:0]   i_cfg_data,
    mfp_in_if.sink                       i_in,
    mfp_out_if.source                    o_out
);

    logic                          acc;
    logic                          in_ready;
    logic                          ram_we;
    logic [mfp_pkg::REC_AW-1:0]    ram_waddr;
    logic [mfp_pkg::REC_W-1:0]     ram_wdata;
    logic                          ram_re;
    logic [mfp_pkg::REC_AW-1:0]    ram_raddr;
    logic [mfp_pkg::REC_W-1:0]     ram_rdata;
    mfp_pkg::t_upd                 upd;
    mfp_pkg::t_rec_sel             rsel;
    mfp_pkg::t_stat                stat;

    assign i_in.ready = in_ready;
    assign acc        = i_in.valid && in_ready;

    // event stage
    mfp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_acc       (acc),
        .i_cmd       (i_in.cmd),
        .i_meas      (i_in.meas_value),
        .i_clock     (i_in.clock_value),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .o_upd       (upd),
        .o_rsel      (rsel),
        .o_stat      (stat)
    );

    // record store: measured value over date
    mfp_ram #(
        .WIDTH (mfp_pkg::REC_W),
        .DEPTH (mfp_pkg::RECORD_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // output stage
    mfp_disp u_disp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (acc),
        .i_upd      (upd),
        .i_rsel     (rsel),
        .i_stat     (stat),
        .i_rdata    (ram_rdata),
        .o_in_ready (in_ready),
        .o_out      (o_out)
    );

endmodule

[design/mfp_ram.sv]
// ----------------------------------------------------------------------------
// mfp_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module mfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

[design/mfp_ctrl.sv]
// ----------------------------------------------------------------------------
// mfp_ctrl
// Event stage: holds power, mode, timers, blink and countdown state, works
// one event per cycle while the output stage takes events, drives the record
// store and registers the display update for the output stage.
// ----------------------------------------------------------------------------
module mfp_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mfp_pkg::CFG_IW-1:0]    i_cfg_idx,
    input  logic [mfp_pkg::CFG_DW-1:0]    i_cfg_data,
    input  logic                          i_acc,
    input  logic [mfp_pkg::CMD_W-1:0]     i_cmd,
    input  logic [mfp_pkg::VAL_W-1:0]     i_meas,
    input  logic [mfp_pkg::DATE_W-1:0]    i_clock,
    output logic                          o_ram_we,
    output logic [mfp_pkg::REC_AW-1:0]    o_ram_waddr,
    output logic [mfp_pkg::REC_W-1:0]     o_ram_wdata,
    output logic                          o_ram_re,
    output logic [mfp_pkg::REC_AW-1:0]    o_ram_raddr,
    output mfp_pkg::t_upd                 o_upd,
    output mfp_pkg::t_rec_sel             o_rsel,
    output mfp_pkg::t_stat                o_stat
);

    // configuration registers
    logic [mfp_pkg::TMR_W-1:0] r_cfg_selftest, r_cfg_view, r_cfg_blink, r_cfg_cd;
    logic [mfp_pkg::DIG_W-1:0] r_cfg_start;

    // control state
    logic                       r_power, n_power;
    logic [mfp_pkg::MODE_W-1:0] r_mode, n_mode;
    logic                       r_stp, n_stp;
    logic [mfp_pkg::TMR_W-1:0]  r_st, n_st;
    logic                       r_armed, n_armed;
    logic [mfp_pkg::TMR_W-1:0]  r_bt, n_bt;
    logic                       r_bso, n_bso;
    logic                       r_bbo, n_bbo;
    logic                       r_sp, n_sp;
    logic                       r_bp, n_bp;
    logic                       r_cdr, n_cdr;
    logic [mfp_pkg::DIG_W-1:0]  r_dig, n_dig;
    logic [mfp_pkg::REC_AW-1:0] r_vi, n_vi;
    logic [mfp_pkg::REC_CW-1:0] r_rc, n_rc;

    // stage payload
    mfp_pkg::t_upd     r_upd, n_upd;
    mfp_pkg::t_rec_sel r_rsel, n_rsel;
    mfp_pkg::t_stat    r_stat, n_stat;

    logic                      show;
    logic                      store;
    logic [mfp_pkg::VAL_W-1:0] meas_sat;

    assign meas_sat = (i_meas > mfp_pkg::MEAS_MAX) ? mfp_pkg::MEAS_MAX : i_meas;

    // configuration writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_selftest <= mfp_pkg::RST_SELFTEST;
            r_cfg_view     <= mfp_pkg::RST_VIEW_TO;
            r_cfg_blink    <= mfp_pkg::RST_BLINK;
            r_cfg_cd       <= mfp_pkg::RST_CD_TICKS;
            r_cfg_start    <= mfp_pkg::RST_CD_START;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mfp_pkg::CFG_SELFTEST: r_cfg_selftest <= i_cfg_data;
                mfp_pkg::CFG_VIEW_TO:  r_cfg_view     <= i_cfg_data;
                mfp_pkg::CFG_BLINK:    r_cfg_blink    <= i_cfg_data;
                mfp_pkg::CFG_CD_TICKS: r_cfg_cd       <= i_cfg_data;
                mfp_pkg::CFG_CD_START: r_cfg_start    <= i_cfg_data[mfp_pkg::DIG_W-1:0];
                default: ;
            endcase
        end
    end

    // event processing
    always_comb begin
        n_power = r_power;
        n_mode  = r_mode;
        n_stp   = r_stp;
        n_st    = r_st;
        n_armed = r_armed;
        n_bt    = r_bt;
        n_bso   = r_bso;
        n_bbo   = r_bbo;
        n_sp    = r_sp;
        n_bp    = r_bp;
        n_cdr   = r_cdr;
        n_dig   = r_dig;
        n_vi    = r_vi;
        n_rc    = r_rc;
        n_upd   = '0;
        show    = 1'b0;
        store   = 1'b0;

        case (i_cmd)
            mfp_pkg::CMD_TICK: begin
                if (n_st != '0) n_st = n_st - 1'b1;
                if (n_bt != '0) n_bt = n_bt - 1'b1;

                // self-test over, show newest record
                if (n_power && n_stp && n_st == '0) begin
                    n_stp            = 1'b0;
                    n_vi             = mfp_pkg::REC_AW'(r_rc - 1'b1);
                    show             = 1'b1;
                    n_upd            = '0;
                    n_upd.main_wr    = 1'b1;
                    n_upd.main_kind  = mfp_pkg::MAIN_VALUE;
                    n_upd.main_rec   = 1'b1;
                    n_upd.sec_wr     = 1'b1;
                    n_upd.date_wr    = 1'b1;
                    n_upd.date_kind  = mfp_pkg::DATE_VALUE;
                    n_upd.date_rec   = 1'b1;
                    n_upd.blood_wr   = 1'b1;
                    n_upd.strip_wr   = 1'b1;
                    n_upd.bat_wr     = 1'b1;
                    n_upd.link_wr    = 1'b1;
                    n_mode           = mfp_pkg::MODE_VIEW;
                    n_st             = r_cfg_view;
                    n_armed          = 1'b1;
                end

                // record view idle timeout, enter measure mode
                if (n_mode == mfp_pkg::MODE_VIEW && !n_stp && n_armed && n_st == '0) begin
                    n_mode          = mfp_pkg::MODE_MEASURE;
                    n_armed         = 1'b0;
                    n_upd.main_wr   = 1'b1;
                    n_upd.main_kind = mfp_pkg::MAIN_BLANK;
                    n_upd.main_rec  = 1'b0;
                    n_upd.main_val  = '0;
                    n_upd.sec_wr    = 1'b1;
                    n_upd.sec       = 1'b0;
                    n_upd.date_wr   = 1'b1;
                    n_upd.date_kind = mfp_pkg::DATE_VALUE;
                    n_upd.date_rec  = 1'b0;
                    n_upd.date_val  = i_clock;
                    n_upd.blood_wr  = 1'b1;
                    n_upd.blood     = 1'b0;
                    n_upd.strip_wr  = 1'b1;
                    n_upd.strip     = 1'b0;
                    n_bso           = 1'b1;
                    n_bbo           = 1'b0;
                    n_sp            = 1'b0;
                    n_bp            = 1'b0;
                    n_bt            = r_cfg_blink;
                end

                // countdown digit or final measurement
                if (n_cdr && n_st == '0) begin
                    n_upd.main_wr  = 1'b1;
                    n_upd.main_rec = 1'b0;
                    if (n_dig != '0) begin
                        n_upd.main_kind = mfp_pkg::MAIN_DIGIT;
                        n_upd.main_val  = mfp_pkg::VAL_W'(n_dig);
                        n_dig           = n_dig - 1'b1;
                        n_st            = r_cfg_cd;
                    end else begin
                        n_cdr           = 1'b0;
                        n_upd.main_kind = mfp_pkg::MAIN_VALUE;
                        n_upd.main_val  = meas_sat;
                        if (r_rc < mfp_pkg::REC_CW'(mfp_pkg::RECORD_DEPTH)) begin
                            store = 1'b1;
                            n_rc  = r_rc + 1'b1;
                        end
                    end
                end

                // icon blinking
                if ((n_bso || n_bbo) && n_bt == '0) begin
                    n_bt = r_cfg_blink;
                    if (n_bso) begin
                        n_sp           = ~n_sp;
                        n_upd.strip_wr = 1'b1;
                        n_upd.strip    = n_sp;
                    end
                    if (n_bbo) begin
                        n_bp           = ~n_bp;
                        n_upd.blood_wr = 1'b1;
                        n_upd.blood    = n_bp;
                    end
                end
            end

            mfp_pkg::CMD_POWER: begin
                n_power = ~r_power;
                if (r_power) begin
                    n_mode          = mfp_pkg::MODE_IDLE;
                    n_stp           = 1'b0;
                    n_cdr           = 1'b0;
                    n_bso           = 1'b0;
                    n_bbo           = 1'b0;
                    n_st            = '0;
                    n_armed         = 1'b0;
                    n_bt            = '0;
                    n_upd.main_wr   = 1'b1;
                    n_upd.main_kind = mfp_pkg::MAIN_BLANK;
                    n_upd.sec_wr    = 1'b1;
                    n_upd.date_wr   = 1'b1;
                    n_upd.date_kind = mfp_pkg::DATE_BLANK;
                    n_upd.blood_wr  = 1'b1;
                    n_upd.strip_wr  = 1'b1;
                end else begin
                    n_upd.main_wr   = 1'b1;
                    n_upd.main_kind = mfp_pkg::MAIN_EIGHTS;
                    n_upd.sec_wr    = 1'b1;
                    n_upd.sec       = 1'b1;
                    n_upd.date_wr   = 1'b1;
                    n_upd.date_kind = mfp_pkg::DATE_EIGHTS;
                    n_upd.blood_wr  = 1'b1;
                    n_upd.blood     = 1'b1;
                    n_upd.strip_wr  = 1'b1;
                    n_upd.strip     = 1'b1;
                    n_upd.bat_wr    = 1'b1;
                    n_upd.bat       = 1'b1;
                    n_upd.link_wr   = 1'b1;
                    n_upd.link      = 1'b1;
                    n_stp           = 1'b1;
                    n_mode          = mfp_pkg::MODE_IDLE;
                    n_st            = r_cfg_selftest;
                    n_armed         = 1'b1;
                end
            end

            mfp_pkg::CMD_UP, mfp_pkg::CMD_DOWN: begin
                if (r_power && r_mode == mfp_pkg::MODE_VIEW) begin
                    if (i_cmd == mfp_pkg::CMD_UP) begin
                        if (mfp_pkg::REC_CW'(r_vi) + 1'b1 < r_rc) begin
                            n_vi = r_vi + 1'b1;
                            show = 1'b1;
                        end
                    end else if (r_vi != '0) begin
                        n_vi = r_vi - 1'b1;
                        show = 1'b1;
                    end
                    if (show) begin
                        n_upd.main_wr   = 1'b1;
                        n_upd.main_kind = mfp_pkg::MAIN_VALUE;
                        n_upd.main_rec  = 1'b1;
                        n_upd.sec_wr    = 1'b1;
                        n_upd.date_wr   = 1'b1;
                        n_upd.date_kind = mfp_pkg::DATE_VALUE;
                        n_upd.date_rec  = 1'b1;
                        n_upd.blood_wr  = 1'b1;
                        n_upd.strip_wr  = 1'b1;
                        n_st            = r_cfg_view;
                        n_armed         = 1'b1;
                    end
                end
            end

            mfp_pkg::CMD_STRIP_IN: begin
                if (r_power && r_mode == mfp_pkg::MODE_MEASURE) begin
                    n_bso          = 1'b0;
                    n_upd.strip_wr = 1'b1;
                    n_upd.strip    = 1'b1;
                    n_bbo          = 1'b1;
                    n_bp           = 1'b0;
                    n_bt           = r_cfg_blink;
                end
            end

            mfp_pkg::CMD_BLOOD: begin
                if (r_power && r_mode == mfp_pkg::MODE_MEASURE) begin
                    n_bbo          = 1'b0;
                    n_upd.blood_wr = 1'b1;
                    n_upd.blood    = 1'b1;
                    n_cdr          = 1'b1;
                    n_dig          = r_cfg_start;
                    n_st           = '0;
                    n_armed        = 1'b1;
                end
            end

            mfp_pkg::CMD_STRIP_OUT: begin
                if (r_power && r_mode == mfp_pkg::MODE_MEASURE) begin
                    n_upd.main_wr   = 1'b1;
                    n_upd.main_kind = mfp_pkg::MAIN_BLANK;
                    n_upd.sec_wr    = 1'b1;
                    n_upd.date_wr   = 1'b1;
                    n_upd.date_kind = mfp_pkg::DATE_BLANK;
                    n_upd.blood_wr  = 1'b1;
                    n_upd.strip_wr  = 1'b1;
                    n_bso           = 1'b1;
                    n_sp            = 1'b0;
                    n_bt            = r_cfg_blink;
                end
            end

            default: ;
        endcase

        n_rsel.preset = (mfp_pkg::REC_CW'(n_vi) < mfp_pkg::REC_CW'(mfp_pkg::PRESET_N));
        n_rsel.pidx   = mfp_pkg::PRESET_AW'(n_vi);

        n_stat.powered = n_power;
        n_stat.mode    = n_mode;
        n_stat.count   = mfp_pkg::CNT_W'(n_rc);
    end

    // control state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power <= 1'b0;
            r_mode  <= mfp_pkg::MODE_IDLE;
            r_stp   <= 1'b0;
            r_st    <= '0;
            r_armed <= 1'b0;
            r_bt    <= '0;
            r_bso   <= 1'b0;
            r_bbo   <= 1'b0;
            r_sp    <= 1'b0;
            r_bp    <= 1'b0;
            r_cdr   <= 1'b0;
            r_dig   <= '0;
            r_vi    <= mfp_pkg::REC_AW'(mfp_pkg::PRESET_N - 1);
            r_rc    <= mfp_pkg::REC_CW'(mfp_pkg::PRESET_N);
        end else if (i_acc) begin
            r_power <= n_power;
            r_mode  <= n_mode;
            r_stp   <= n_stp;
            r_st    <= n_st;
            r_armed <= n_armed;
            r_bt    <= n_bt;
            r_bso   <= n_bso;
            r_bbo   <= n_bbo;
            r_sp    <= n_sp;
            r_bp    <= n_bp;
            r_cdr   <= n_cdr;
            r_dig   <= n_dig;
            r_vi    <= n_vi;
            r_rc    <= n_rc;
        end
    end

    // stage payload, aligned with the store read
    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_upd  <= n_upd;
            r_rsel <= n_rsel;
            r_stat <= n_stat;
        end
    end

    // store access: append on measurement, read the record to show
    assign o_ram_we    = i_acc && store;
    assign o_ram_waddr = r_rc[mfp_pkg::REC_AW-1:0];
    assign o_ram_wdata = {meas_sat, i_clock};
    assign o_ram_re    = i_acc && show && !n_rsel.preset;
    assign o_ram_raddr = n_vi;

    assign o_upd  = r_upd;
    assign o_rsel = r_rsel;
    assign o_stat = r_stat;

endmodule

[design/mfp_disp.sv]
// ----------------------------------------------------------------------------
// mfp_disp
// Output stage: merges the registered display update with the record read
// from the store and holds the display snapshot as the output register.
// ----------------------------------------------------------------------------
module mfp_disp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_acc,
    input  mfp_pkg::t_upd                i_upd,
    input  mfp_pkg::t_rec_sel            i_rsel,
    input  mfp_pkg::t_stat               i_stat,
    input  logic [mfp_pkg::REC_W-1:0]    i_rdata,
    output logic                         o_in_ready,
    mfp_out_if.source                    o_out
);

    logic                         r_s1_vld;
    logic                         r_o_vld;
    logic                         out_free;
    logic                         s1_adv;

    logic                         r_powered;
    logic [mfp_pkg::MODE_W-1:0]   r_mode;
    logic [mfp_pkg::KIND_W-1:0]   r_main_kind, n_main_kind;
    logic [mfp_pkg::VAL_W-1:0]    r_main_val, n_main_val;
    logic                         r_sec, n_sec;
    logic [mfp_pkg::KIND_W-1:0]   r_date_kind, n_date_kind;
    logic [mfp_pkg::DATE_W-1:0]   r_date_val, n_date_val;
    logic                         r_blood, n_blood;
    logic                         r_strip, n_strip;
    logic                         r_bat, n_bat;
    logic                         r_link, n_link;
    logic [mfp_pkg::CNT_W-1:0]    r_count;

    logic [mfp_pkg::VAL_W-1:0]    rec_val;
    logic [mfp_pkg::DATE_W-1:0]   rec_date;

    // handshake: the stage moves on when the output register is free
    assign out_free   = !r_o_vld || o_out.ready;
    assign s1_adv     = r_s1_vld && out_free;
    assign o_in_ready = !r_s1_vld || out_free;

    // record source: preset table or store
    assign rec_val  = i_rsel.preset ? mfp_pkg::preset_value(i_rsel.pidx)
                                    : i_rdata[mfp_pkg::REC_W-1:mfp_pkg::DATE_W];
    assign rec_date = i_rsel.preset ? mfp_pkg::preset_date(i_rsel.pidx)
                                    : i_rdata[mfp_pkg::DATE_W-1:0];

    // merge update into the current display
    always_comb begin
        n_main_kind = i_upd.main_wr ? i_upd.main_kind : r_main_kind;
        n_main_val  = i_upd.main_wr ? (i_upd.main_rec ? rec_val : i_upd.main_val)
                                    : r_main_val;
        n_sec       = i_upd.sec_wr ? i_upd.sec : r_sec;
        n_date_kind = i_upd.date_wr ? i_upd.date_kind : r_date_kind;
        n_date_val  = i_upd.date_wr ? (i_upd.date_rec ? rec_date : i_upd.date_val)
                                    : r_date_val;
        n_blood     = i_upd.blood_wr ? i_upd.blood : r_blood;
        n_strip     = i_upd.strip_wr ? i_upd.strip : r_strip;
        n_bat       = i_upd.bat_wr ? i_upd.bat : r_bat;
        n_link      = i_upd.link_wr ? i_upd.link : r_link;
    end

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            if (i_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_o_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    // display snapshot, also the display state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_powered   <= 1'b0;
            r_mode      <= mfp_pkg::MODE_IDLE;
            r_main_kind <= mfp_pkg::MAIN_BLANK;
            r_main_val  <= '0;
            r_sec       <= 1'b0;
            r_date_kind <= mfp_pkg::DATE_BLANK;
            r_date_val  <= '0;
            r_blood     <= 1'b0;
            r_strip     <= 1'b0;
            r_bat       <= 1'b0;
            r_link      <= 1'b0;
            r_count     <= mfp_pkg::CNT_W'(mfp_pkg::PRESET_N);
        end else if (s1_adv) begin
            r_powered   <= i_stat.powered;
            r_mode      <= i_stat.mode;
            r_main_kind <= n_main_kind;
            r_main_val  <= n_main_val;
            r_sec       <= n_sec;
            r_date_kind <= n_date_kind;
            r_date_val  <= n_date_val;
            r_blood     <= n_blood;
            r_strip     <= n_strip;
            r_bat       <= n_bat;
            r_link      <= n_link;
            r_count     <= i_stat.count;
        end
    end

    assign o_out.valid         = r_o_vld;
    assign o_out.powered       = r_powered;
    assign o_out.mode_now      = r_mode;
    assign o_out.main_kind     = r_main_kind;
    assign o_out.main_value    = r_main_val;
    assign o_out.second_eights = r_sec;
    assign o_out.date_kind     = r_date_kind;
    assign o_out.date_value    = r_date_val;
    assign o_out.blood_icon    = r_blood;
    assign o_out.strip_icon    = r_strip;
    assign o_out.battery_icon  = r_bat;
    assign o_out.link_icon     = r_link;
    assign o_out.stored_count  = r_count;

endmodule

[design/mfp_chk.sv]
// ----------------------------------------------------------------------------
// mfp_chk
// Port-level checks of the front-panel controller, bound to the top level.
// ----------------------------------------------------------------------------
module mfp_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         i_ready,
    input logic                         i_powered,
    input logic [mfp_pkg::MODE_W-1:0]   i_mode,
    input logic [mfp_pkg::KIND_W-1:0]   i_main_kind,
    input logic [mfp_pkg::VAL_W-1:0]    i_main_value,
    input logic                         i_second,
    input logic [mfp_pkg::KIND_W-1:0]   i_date_kind,
    input logic [mfp_pkg::DATE_W-1:0]   i_date_value,
    input logic                         i_blood,
    input logic                         i_strip
);

    // stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_main_value) && $stable(i_date_value)
                                && $stable(i_mode))
        else $error("output word changed while stalled");

    // powered off means idle mode, blank main and date digits, no blood or strip icon
    a_off_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_powered |-> i_mode == mfp_pkg::MODE_IDLE
            && i_main_kind == mfp_pkg::MAIN_BLANK && i_date_kind == mfp_pkg::DATE_BLANK
            && !i_blood && !i_strip)
        else $error("panel not blank while off");

    // values only accompany kinds that show them
    a_value_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_main_value == '0 || i_main_kind == mfp_pkg::MAIN_VALUE
                     || i_main_kind == mfp_pkg::MAIN_DIGIT)
                 && (i_date_value == '0 || i_date_kind == mfp_pkg::DATE_VALUE))
        else $error("value shown with non-value digit kind");

    // self-test pattern never survives into view or measure mode
    a_no_test: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_mode == mfp_pkg::MODE_VIEW || i_mode == mfp_pkg::MODE_MEASURE)
            |-> !i_second && i_main_kind != mfp_pkg::MAIN_EIGHTS
                && i_date_kind != mfp_pkg::DATE_EIGHTS)
        else $error("self-test pattern outside self-test");

endmodule

bind meter_front_panel_controller mfp_chk u_mfp_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_out.valid),
    .i_ready      (o_out.ready),
    .i_powered    (o_out.powered),
    .i_mode       (o_out.mode_now),
    .i_main_kind  (o_out.main_kind),
    .i_main_value (o_out.main_value),
    .i_second     (o_out.second_eights),
    .i_date_kind  (o_out.date_kind),
    .i_date_value (o_out.date_value),
    .i_blood      (o_out.blood_icon),
    .i_strip      (o_out.strip_icon)
);
